// ===== rtl/core/bpcw_pkg.sv =====
// Shared types, constants and bit-step functions for the BLE PDU CRC/whitening encoder.
// No dependencies; imported by every module of the core.
package bpcw_pkg;

	localparam int BYTE_W      = 8;
	localparam int CRC_W       = 24;
	localparam int CHAN_W      = 6;
	localparam int CFG_INDEX_W = 2;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CRC_W-1:0]       CRC_TAPS        = 24'h00065B;
	localparam logic [BYTE_W-1:0]      WHITEN_FEEDBACK = 8'h11;
	localparam logic [CRC_W-1:0]       CRC_INIT_RESET  = 24'h555555;
	localparam logic [CHAN_W-1:0]      CHAN_RESET      = 6'd37;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_CRC_INIT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHAN_SEL = 2'd1;

	// config write strobes toward front (CRC) and back (LFSR)
	typedef struct packed {
		logic             crc_we;
		logic             chan_we;
		logic [CRC_W-1:0] data;
	} cfg_wr_t;

	// one queued PDU byte with the CRC it leaves behind
	typedef struct packed {
		logic [BYTE_W-1:0] pdu;
		logic              last;
		logic [CRC_W-1:0]  crc;
	} q_entry_t;

	typedef struct packed {
		logic [BYTE_W-1:0] lfsr;
		logic [BYTE_W-1:0] data;
	} whiten_t;

	typedef enum logic [1:0] {
		PH_PDU,
		PH_CRC_HI,
		PH_CRC_MID,
		PH_CRC_LO
	} phase_t;

	function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] x);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = x[BYTE_W-1-i];
		end
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] lfsr_seed(input logic [CHAN_W-1:0] chan);
		return rev8({2'b00, chan}) | 8'h02;
	endfunction

	// eight CRC-24 steps, data LSB first
	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] d);
		logic [CRC_W-1:0] c;
		logic             top;
		c = crc;
		for (int i = 0; i < BYTE_W; i++) begin
			top = c[CRC_W-1];
			c = {c[CRC_W-2:0], 1'b0};
			if (top != d[i]) begin
				c = c ^ CRC_TAPS;
			end
		end
		return c;
	endfunction

	// eight whitening steps, data LSB first
	function automatic whiten_t whiten8(input logic [BYTE_W-1:0] lfsr,
		input logic [BYTE_W-1:0] d);
		whiten_t w;
		w.lfsr = lfsr;
		w.data = d;
		for (int i = 0; i < BYTE_W; i++) begin
			if (w.lfsr[BYTE_W-1]) begin
				w.lfsr = w.lfsr ^ WHITEN_FEEDBACK;
				w.data[i] = ~w.data[i];
			end
			w.lfsr = {w.lfsr[BYTE_W-2:0], 1'b0};
		end
		return w;
	endfunction

endpackage

// ===== rtl/core/ble_pdu_crc_whiten_encoder_core.sv =====
// BLE PDU encoder top level: CRC-24 generation and data whitening for one packet stream.
// Depends on bpcw_pkg, bpcw_front, bpcw_queue and bpcw_back.
//
// PDU bytes enter one per transaction on the in channel, header first, with last_byte set
// on the final one. Each byte comes out whitened and bit-reversed on the out channel; after
// the last byte three more bytes follow (is_crc = 1), the CRC-24 high byte first, the third
// one flagged end_of_packet. The CRC register and whitening LFSR then reload from crc_init
// and the channel register. Input bytes are taken one per cycle while the QUEUE_DEPTH-entry
// queue has room; the back end emits one byte per cycle unless out_ready stalls, so a packet
// of N PDU bytes gives N + 3 output bytes; that output pace sets the sustained input rate.
// An accepted byte passes the queue write, then the output register. Config writes
// (cfg_index 0 = crc_init, 1 = channel index, others ignored) are always accepted and take
// effect at once, restarting the matching register; write them only while the core is idle.
module ble_pdu_crc_whiten_encoder_core import bpcw_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CRC_W-1:0]       cfg_data,
	// PDU byte input channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [BYTE_W-1:0]      pdu_byte,
	input  logic                   last_byte,
	// air byte output channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [BYTE_W-1:0]      air_byte,
	output logic                   is_crc,
	output logic                   end_of_packet
);

	cfg_wr_t  cfg;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	q_entry_t q_wdata;
	q_entry_t q_head;

	// config port never stalls
	assign cfg_ready   = 1'b1;
	assign cfg.crc_we  = cfg_valid && (cfg_index == CFG_CRC_INIT);
	assign cfg.chan_we = cfg_valid && (cfg_index == CFG_CHAN_SEL);
	assign cfg.data    = cfg_data;

	// front: accept and CRC each byte
	bpcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pdu_byte  (pdu_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// queue: byte plus post-byte CRC snapshot
	bpcw_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// back: whiten, append CRC bytes, output register
	bpcw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head          (q_head),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.air_byte      (air_byte),
		.is_crc        (is_crc),
		.end_of_packet (end_of_packet)
	);

endmodule

// ===== rtl/core/bpcw_front.sv =====
// Front end: accepts PDU byte transactions and runs the CRC-24 over them.
// Depends on bpcw_pkg; feeds bpcw_queue.
module bpcw_front import bpcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_wr_t           cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] pdu_byte,
	input  logic              last_byte,
	input  logic              q_full,
	output logic              q_push,
	output q_entry_t          q_data
);

	logic [CRC_W-1:0] crc_init_q;
	logic [CRC_W-1:0] crc_q;
	logic [CRC_W-1:0] crc_next;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign crc_next = crc_feed(crc_q, pdu_byte);

	assign q_data.pdu  = pdu_byte;
	assign q_data.last = last_byte;
	assign q_data.crc  = crc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_init_q <= CRC_INIT_RESET;
			crc_q      <= CRC_INIT_RESET;
		end else if (cfg.crc_we) begin
			crc_init_q <= cfg.data;
			crc_q      <= cfg.data;
		end else if (q_push) begin
			// reload for the next packet after the last byte
			crc_q <= last_byte ? crc_init_q : crc_next;
		end
	end

endmodule

// ===== rtl/core/bpcw_queue.sv =====
// Small FIFO that decouples the CRC front end from the whitening back end.
// Depends on bpcw_pkg for the entry type.
module bpcw_queue import bpcw_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output q_entry_t head,
	output logic     empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/bpcw_back.sv =====
// Back end: whitens queued PDU bytes, appends the three CRC bytes, drives the output register.
// Depends on bpcw_pkg; drains bpcw_queue.
module bpcw_back import bpcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_wr_t           cfg,
	input  q_entry_t          head,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] air_byte,
	output logic              is_crc,
	output logic              end_of_packet
);

	phase_t            phase_q, phase_d;
	logic [CHAN_W-1:0] chan_q;
	logic [BYTE_W-1:0] lfsr_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] air_q;
	logic              is_crc_q;
	logic              eop_q;

	logic              fire;
	logic [BYTE_W-1:0] din;
	whiten_t           w;

	assign fire = (!out_valid_q || out_ready) && !q_empty;
	assign w    = whiten8(lfsr_q, din);

	always_comb begin
		phase_d = phase_q;
		q_pop   = 1'b0;
		case (phase_q)
			PH_PDU:     din = head.pdu;
			PH_CRC_HI:  din = rev8(head.crc[23:16]);
			PH_CRC_MID: din = rev8(head.crc[15:8]);
			PH_CRC_LO:  din = rev8(head.crc[7:0]);
			default:    din = head.pdu;
		endcase
		if (fire) begin
			case (phase_q)
				PH_PDU: begin
					if (head.last) begin
						phase_d = PH_CRC_HI;
					end else begin
						q_pop = 1'b1;
					end
				end
				PH_CRC_HI:  phase_d = PH_CRC_MID;
				PH_CRC_MID: phase_d = PH_CRC_LO;
				PH_CRC_LO: begin
					phase_d = PH_PDU;
					q_pop   = 1'b1;
				end
				default:    phase_d = PH_PDU;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PDU;
			out_valid_q <= 1'b0;
			chan_q      <= CHAN_RESET;
			lfsr_q      <= lfsr_seed(CHAN_RESET);
		end else begin
			phase_q <= phase_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.chan_we) begin
				chan_q <= cfg.data[CHAN_W-1:0];
				lfsr_q <= lfsr_seed(cfg.data[CHAN_W-1:0]);
			end else if (fire) begin
				// reseed after the final CRC byte
				lfsr_q <= (phase_q == PH_CRC_LO) ? lfsr_seed(chan_q) : w.lfsr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			air_q    <= rev8(w.data);
			is_crc_q <= (phase_q != PH_PDU);
			eop_q    <= (phase_q == PH_CRC_LO);
		end
	end

	assign out_valid     = out_valid_q;
	assign air_byte      = air_q;
	assign is_crc        = is_crc_q;
	assign end_of_packet = eop_q;

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for ble_pdu_crc_whiten_encoder_core: BLE CRC-24 plus data whitening.
// Needs bpcw_pkg and the core RTL. A local shadow encoder predicts every air byte, and a
// scoreboard checks each output transaction, in order, against it.
module tb_top;
	import bpcw_pkg::*;

	// spec constants, kept apart from the RTL package on purpose
	localparam logic [CRC_W-1:0]       LE_CRC_POLY    = 24'h00065B;
	localparam logic [BYTE_W-1:0]      WHITEN_TAP     = 8'h11;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO   = 2'd2;  // no register behind these
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI   = 2'd3;
	localparam int                     RANDOM_BYTES   = 350;
	localparam int                     SETTLE_CYCLES  = 4;
	localparam int                     CYCLE_LIMIT    = 200000;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              last;
	} pdu_item_t;

	typedef struct {
		logic [BYTE_W-1:0] air;
		logic              crc;
		logic              eop;
	} air_item_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_PATTERN
	} sink_mode_t;

	logic                   clk;
	logic                   arst_n     = 1'b0;
	logic                   cfg_valid  = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index  = '0;
	logic [CRC_W-1:0]       cfg_data   = '0;
	logic                   in_valid   = 1'b0;
	logic                   in_ready;
	logic [BYTE_W-1:0]      pdu_byte   = '0;
	logic                   last_byte  = 1'b0;
	logic                   out_valid;
	logic                   out_ready  = 1'b0;
	logic [BYTE_W-1:0]      air_byte;
	logic                   is_crc;
	logic                   end_of_packet;

	ble_pdu_crc_whiten_encoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pdu_byte      (pdu_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.air_byte      (air_byte),
		.is_crc        (is_crc),
		.end_of_packet (end_of_packet)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow encoder: its own copy of the config and of both registers
	// ------------------------------------------------------------------
	logic [CRC_W-1:0]  crc_start;
	logic [CHAN_W-1:0] chan_sel;
	logic [CRC_W-1:0]  crc_shadow;
	logic [BYTE_W-1:0] lfsr_shadow;

	pdu_item_t pdu_pending[$];   // bytes waiting for the input driver
	air_item_t air_expected[$];  // air bytes predicted, not yet seen
	int        errors      = 0;
	int        cycle_count = 0;

	function automatic logic [BYTE_W-1:0] bit_mirror(input logic [BYTE_W-1:0] x);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[BYTE_W-1-i] = x[i];
		end
		return r;
	endfunction

	// channel index lands reversed in the top six bits; bit 1 is always set
	function automatic logic [BYTE_W-1:0] whiten_seed(input logic [CHAN_W-1:0] ch);
		return bit_mirror({2'b00, ch}) | 8'h02;
	endfunction

	// CRC-24, data LSB first, feedback = outgoing top bit xor data bit
	task automatic crc_absorb(input logic [BYTE_W-1:0] d);
		logic fb;
		for (int i = 0; i < BYTE_W; i++) begin
			fb = crc_shadow[CRC_W-1] ^ d[i];
			crc_shadow = {crc_shadow[CRC_W-2:0], 1'b0} ^ (fb ? LE_CRC_POLY : '0);
		end
	endtask

	// whitening: eight LFSR steps, each taken from bit 7, flip data LSB first
	task automatic whiten_next(input logic [BYTE_W-1:0] d, output logic [BYTE_W-1:0] w);
		w = d;
		for (int i = 0; i < BYTE_W; i++) begin
			if (lfsr_shadow[BYTE_W-1]) begin
				lfsr_shadow = lfsr_shadow ^ WHITEN_TAP;
				w[i] = ~w[i];
			end
			lfsr_shadow = {lfsr_shadow[BYTE_W-2:0], 1'b0};
		end
	endtask

	// one accepted PDU byte -> one air byte, plus three CRC bytes on the last one
	task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic last);
		air_item_t         item;
		logic [BYTE_W-1:0] w;
		logic [BYTE_W-1:0] cb;
		crc_absorb(b);
		whiten_next(b, w);
		item.air = bit_mirror(w);
		item.crc = 1'b0;
		item.eop = 1'b0;
		air_expected.push_back(item);
		if (last) begin
			// CRC goes out high byte first, reversed into the whitener and reversed back
			for (int k = 0; k < 3; k++) begin
				cb = crc_shadow[CRC_W-1-8*k -: 8];
				whiten_next(bit_mirror(cb), w);
				item.air = bit_mirror(w);
				item.crc = 1'b1;
				item.eop = (k == 2);
				air_expected.push_back(item);
			end
			crc_shadow  = crc_start;
			lfsr_shadow = whiten_seed(chan_sel);
		end
	endtask

	// ------------------------------------------------------------------
	// Scoreboard: output check first, then config and input prediction.
	// Inputs reach the outputs through the queue and output register, so
	// this order never pairs a result with an item taken on the same edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		air_item_t want;
		if (!arst_n) begin
			crc_start   = CRC_INIT_RESET;
			chan_sel    = CHAN_RESET;
			crc_shadow  = CRC_INIT_RESET;
			lfsr_shadow = whiten_seed(CHAN_RESET);
		end else if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d air bytes still outstanding", $time,
				air_expected.size());
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			cycle_count++;
			if (out_valid && out_ready) begin
				if (air_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected air byte, expected none, actual %02h crc %0b eop %0b",
						$time, air_byte, is_crc, end_of_packet);
				end else begin
					want = air_expected.pop_front();
					if (air_byte !== want.air) begin
						errors++;
						$display("%0t: air_byte mismatch, expected %02h actual %02h",
							$time, want.air, air_byte);
					end
					if (is_crc !== want.crc) begin
						errors++;
						$display("%0t: is_crc mismatch, expected %0b actual %0b",
							$time, want.crc, is_crc);
					end
					if (end_of_packet !== want.eop) begin
						errors++;
						$display("%0t: end_of_packet mismatch, expected %0b actual %0b",
							$time, want.eop, end_of_packet);
					end
				end
			end
			// a config write restarts the matching register, even mid-packet
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CRC_INIT: begin
						crc_start  = cfg_data;
						crc_shadow = cfg_data;
					end
					CFG_CHAN_SEL: begin
						chan_sel    = cfg_data[CHAN_W-1:0];
						lfsr_shadow = whiten_seed(cfg_data[CHAN_W-1:0]);
					end
					default: ;  // spare indexes are ignored
				endcase
			end
			if (in_valid && in_ready) begin
				encode_byte(pdu_byte, last_byte);
			end
		end
	end

	// ------------------------------------------------------------------
	// Input driver: bursts of random length, random gaps in between.
	// Valid holds with a stable payload until the transaction completes.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		pdu_item_t nxt;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			pdu_byte  <= '0;
			last_byte <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0 || pdu_pending.size() == 0) begin
				if (gap_left != 0) begin
					gap_left--;
				end
				in_valid <= 1'b0;
			end else begin
				nxt = pdu_pending.pop_front();
				in_valid  <= 1'b1;
				pdu_byte  <= nxt.data;
				last_byte <= nxt.last;
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					// now and then a long unbroken stream, otherwise short bursts
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
						: $urandom_range(0, 8);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output sink: ready follows a mode that changes every so often --
	// always open, a biased coin, or a rotating bit pattern.
	// ------------------------------------------------------------------
	sink_mode_t  sink_mode  = SINK_OPEN;
	int          mode_left  = 0;
	int          coin_pct   = 50;
	logic [15:0] stall_bits = 16'h00FF;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			mode_left  = 40;
		end else begin
			stall_bits = {stall_bits[14:0], stall_bits[15]};
			case (sink_mode)
				SINK_OPEN:    out_ready <= 1'b1;
				SINK_COIN:    out_ready <= ($urandom_range(1, 100) <= coin_pct);
				default:      out_ready <= stall_bits[0];
			endcase
			if (mode_left != 0) begin
				mode_left--;
			end else begin
				sink_mode  = sink_mode_t'($urandom_range(0, 2));
				mode_left  = $urandom_range(16, 200);
				coin_pct   = $urandom_range(25, 90);
				stall_bits = 16'($urandom()) | 16'h0001;  // never all stall
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic push_pdu(input logic [BYTE_W-1:0] d, input logic last);
		pdu_item_t item;
		item.data = d;
		item.last = last;
		pdu_pending.push_back(item);
	endtask

	// sender holds off until every predicted air byte is out; ends on a falling edge
	task automatic wait_drained;
		@(negedge clk);
		while (pdu_pending.size() != 0 || in_valid || air_expected.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// call just past a rising edge; valid stays up across back-to-back writes
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CRC_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic close_writes;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int                random_sent;
		int                len;
		logic [CRC_W-1:0]  val;
		logic [CHAN_W-1:0] ch;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part ---
		// reset values: advertising CRC init and channel 37, byte extremes
		push_pdu(8'h00, 1'b0);
		push_pdu(8'hFF, 1'b0);
		push_pdu(8'h80, 1'b0);
		push_pdu(8'h01, 1'b1);
		push_pdu(8'h55, 1'b1);  // one-byte packet
		wait_drained();

		// all-zero init and channel 0; a spare index must change nothing
		@(posedge clk);
		write_reg(CFG_CRC_INIT, 24'h000000);
		write_reg(CFG_CHAN_SEL, 24'h000000);
		write_reg(CFG_SPARE_LO, 24'hA5A5A5);
		close_writes();
		push_pdu(8'h00, 1'b1);
		push_pdu(8'hFF, 1'b0);
		push_pdu(8'hAA, 1'b1);
		wait_drained();

		// all-ones init, top legal channel
		@(posedge clk);
		write_reg(CFG_CRC_INIT, 24'hFFFFFF);
		write_reg(CFG_CHAN_SEL, 24'd39);
		write_reg(CFG_SPARE_HI, 24'hFFFFFF);
		close_writes();
		push_pdu(8'hFF, 1'b0);
		push_pdu(8'h00, 1'b1);
		wait_drained();

		// channel out of range: all-ones data gives channel 63, upper bits dropped
		@(posedge clk);
		write_reg(CFG_CRC_INIT, 24'h123456);
		write_reg(CFG_CHAN_SEL, 24'hFFFFFF);
		close_writes();
		push_pdu(8'h5A, 1'b1);
		push_pdu(8'h01, 1'b0);
		push_pdu(8'hFE, 1'b1);
		wait_drained();

		// first channel past the legal range, then leave a packet open
		@(posedge clk);
		write_reg(CFG_CHAN_SEL, 24'd40);
		close_writes();
		push_pdu(8'h12, 1'b0);
		push_pdu(8'h34, 1'b0);
		wait_drained();

		// mid-packet writes restart CRC and LFSR for the remaining bytes
		@(posedge clk);
		write_reg(CFG_CRC_INIT, 24'hABCDEF);
		close_writes();
		push_pdu(8'h56, 1'b0);
		wait_drained();
		@(posedge clk);
		write_reg(CFG_CHAN_SEL, 24'd1);
		close_writes();
		push_pdu(8'h7F, 1'b0);
		push_pdu(8'h80, 1'b1);
		wait_drained();

		// --- random part: phases of packets, new settings between phases ---
		random_sent = 0;
		while (random_sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 4) != 0) begin
				@(posedge clk);
				if ($urandom_range(0, 2) != 0) begin
					case ($urandom_range(0, 3))
						0:       val = 24'h000000;
						1:       val = 24'hFFFFFF;
						default: val = CRC_W'($urandom());
					endcase
					write_reg(CFG_CRC_INIT, val);
				end
				if ($urandom_range(0, 2) != 0) begin
					case ($urandom_range(0, 5))
						0:       ch = 6'd0;
						1:       ch = 6'd39;
						2:       ch = CHAN_W'($urandom_range(40, 63));
						default: ch = CHAN_W'($urandom_range(0, 39));
					endcase
					val = CRC_W'($urandom());  // junk above the channel field
					val[CHAN_W-1:0] = ch;
					write_reg(CFG_CHAN_SEL, val);
				end
				if ($urandom_range(0, 5) == 0) begin
					write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
						CRC_W'($urandom()));
				end
				close_writes();
			end
			// mostly short packets, a few long ones
			repeat ($urandom_range(1, 5)) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					push_pdu(BYTE_W'($urandom()), i == len - 1);
				end
				random_sent += len;
			end
			// sometimes stop inside a packet so the next settings land mid-packet
			if ($urandom_range(0, 3) == 0) begin
				len = $urandom_range(1, 5);
				repeat (len) push_pdu(BYTE_W'($urandom()), 1'b0);
				random_sent += len;
			end
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
